/* design/mfb_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the framebuffer engine.
package mfb_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_PAGES   = 8;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PAGES;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int PG_W        = $clog2(MAX_PAGES);
  localparam int CW          = 13;

  localparam logic [7:0] RESET_WIDTH  = 8'd128;
  localparam logic [6:0] RESET_HEIGHT = 7'd64;
  localparam logic [7:0] COL_LIMIT    = 8'(MAX_COLUMNS);
  localparam logic [6:0] ROW_LIMIT    = 7'(MAX_PAGES * 8);

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [2:0] BIT_TOP   = 3'd7;

  localparam logic [2:0] FN_PIXEL = 3'd0;
  localparam logic [2:0] FN_HLINE = 3'd1;
  localparam logic [2:0] FN_VLINE = 3'd2;
  localparam logic [2:0] FN_READ  = 3'd3;
  localparam logic [2:0] FN_FETCH = 3'd4;
  localparam logic [2:0] FN_CLEAR = 3'd5;
  localparam logic [2:0] FN_CLOSE = 3'd6;

  localparam logic [1:0] CLR_OFF = 2'd0;
  localparam logic [1:0] CLR_ON  = 2'd1;
  localparam logic [1:0] CLR_INV = 2'd2;

  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic load_in;
    logic map;
    logic clip;
    logic setup;
    logic issue;
    logic sweep;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic is_clear;
    logic last;
  } dp_sts_t;

endpackage

/* design/mfb_ram.sv */
// Generic simple dual-port RAM with registered read.
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mfb_ctrl.sv */
// Command sequencer for the framebuffer engine.
module mfb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mfb_pkg::dp_sts_t sts,
  output mfb_pkg::dp_cmd_t cmd
);
  import mfb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MAP   = 8'b0000_0010,
    S_CLIP  = 8'b0000_0100,
    S_SETUP = 8'b0000_1000,
    S_RUN   = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_SWEEP = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   reply, reply_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    reply_next = reply;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = S_CLIP;
      end
      S_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.is_clear) begin
          reply_next = 1'b1;
          state_next = S_SWEEP;
        end else if (sts.active) begin
          state_next = S_RUN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.last) begin
          reply_next = 1'b0;
          state_next = reply ? S_DONE : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      reply     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/mfb_dp.sv */
// Datapath: config registers, coordinate mapping, clipping, dirty box and store access.
module mfb_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic [2:0]       func,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  input  logic signed [9:0] length,
  input  logic [1:0]       color,
  input  logic [2:0]       fetch_page,
  input  logic [6:0]       fetch_column,
  input  mfb_pkg::dp_cmd_t cmd,
  output mfb_pkg::dp_sts_t sts,
  output logic             pixel_value,
  output logic [7:0]       byte_data,
  output logic             window_valid,
  output logic [7:0]       dirty_x_low,
  output logic [7:0]       dirty_y_low,
  output logic [7:0]       dirty_x_high,
  output logic [7:0]       dirty_y_high
);
  import mfb_pkg::*;

  // configuration
  logic [1:0] rotation;
  logic [7:0] panel_width;
  logic [6:0] panel_height;
  logic [7:0] ew;
  logic [6:0] eh;

  // captured command
  logic [2:0]        func_r;
  logic signed [9:0] x_r, y_r, len_r;
  logic [1:0]        color_r;
  logic [2:0]        fpage_r;
  logic [6:0]        fcol_r;

  // mapped and clipped span
  logic   m_horiz;
  coord_t m_a, m_c, m_len;
  logic   k_horiz, k_ok;
  logic [7:0] k_lo, k_hi, k_c;

  // box
  logic [7:0] bx_lo, by_lo, bx_hi, by_hi;
  logic       box_ok;

  // run control
  logic [AW-1:0]   cur_addr, step, cnt;
  logic [PG_W-1:0] cur_pg;
  logic            p_valid;
  logic [AW-1:0]   p_addr;
  logic [7:0]      p_mask;
  logic            pix_r;
  logic [7:0]      byte_r;

  // comb
  coord_t xs, ys, lv, wv, hv, a_n, c_n;
  logic   horiz_n;
  coord_t alim, clim, a0, l1, l2, send;
  logic   c_ok;
  logic   is_draw, fetch_ok;
  logic [7:0]      row, pages;
  logic [PG_W-1:0] mul_page, lo_pg, hi_pg;
  logic [7:0]      mul_col;
  logic [AW:0]     prod;
  logic [7:0]      lo_m, hi_m, run_mask;
  logic [7:0]      rdata, wdata, mod_data;
  logic            we;
  logic [AW-1:0]   waddr;

  assign ew = (panel_width > COL_LIMIT) ? COL_LIMIT : panel_width;
  assign eh = (panel_height > ROW_LIMIT) ? ROW_LIMIT : panel_height;
  assign wv = coord_t'(ew);
  assign hv = coord_t'(eh);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation     <= 2'd0;
      panel_width  <= RESET_WIDTH;
      panel_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION: rotation     <= cfg_data[1:0];
        REG_WIDTH:    panel_width  <= cfg_data;
        REG_HEIGHT:   panel_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // view to panel; a pixel or read is a one-pixel horizontal view line
  assign xs = coord_t'(x_r);
  assign ys = coord_t'(y_r);
  assign lv = (func_r == FN_PIXEL || func_r == FN_READ) ? coord_t'(1) : coord_t'(len_r);

  always_comb begin
    a_n     = xs;
    c_n     = ys;
    horiz_n = 1'b1;
    if (func_r == FN_VLINE) begin
      case (rotation)
        2'd0: begin horiz_n = 1'b0; a_n = ys;           c_n = xs;           end
        2'd1: begin horiz_n = 1'b1; a_n = wv - ys - lv; c_n = xs;           end
        2'd2: begin horiz_n = 1'b0; a_n = hv - ys - lv; c_n = wv - xs - coord_t'(1); end
        default: begin horiz_n = 1'b1; a_n = ys;        c_n = hv - xs - coord_t'(1); end
      endcase
    end else begin
      case (rotation)
        2'd0: begin horiz_n = 1'b1; a_n = xs;           c_n = ys;           end
        2'd1: begin horiz_n = 1'b0; a_n = xs;           c_n = wv - ys - coord_t'(1); end
        2'd2: begin horiz_n = 1'b1; a_n = wv - xs - lv; c_n = hv - ys - coord_t'(1); end
        default: begin horiz_n = 1'b0; a_n = hv - xs - lv; c_n = ys;        end
      endcase
    end
  end

  // clip to the panel
  assign alim = m_horiz ? wv : hv;
  assign clim = m_horiz ? hv : wv;
  assign c_ok = (m_c >= 0) && (m_c < clim);
  assign a0   = (m_a < 0) ? coord_t'(0) : m_a;
  assign l1   = (m_a < 0) ? m_len + m_a : m_len;
  assign l2   = (a0 + l1 > alim) ? alim - a0 : l1;
  assign send = a0 + l2 - coord_t'(1);

  // address setup
  assign is_draw  = (func_r == FN_PIXEL) || (func_r == FN_HLINE) || (func_r == FN_VLINE);
  assign pages    = ({1'b0, eh} + 8'd7) >> 3;
  assign fetch_ok = ({5'd0, fpage_r} < pages) && ({1'b0, fcol_r} < ew);
  assign row      = k_horiz ? k_c : k_lo;
  assign lo_pg    = k_lo[PG_W+2:3];
  assign hi_pg    = k_hi[PG_W+2:3];
  assign mul_page = (func_r == FN_FETCH) ? PG_W'(fpage_r) : row[PG_W+2:3];
  assign mul_col  = (func_r == FN_FETCH) ? {1'b0, fcol_r} : (k_horiz ? k_lo : k_c);
  assign prod     = (AW+1)'(mul_page) * (AW+1)'(ew) + (AW+1)'(mul_col);

  assign sts.active   = (((is_draw || func_r == FN_READ) && k_ok) ||
                         (func_r == FN_FETCH && fetch_ok));
  assign sts.is_clear = (func_r == FN_CLEAR);
  assign sts.last     = (cnt == '0);

  // per-byte mask; a vertical span covers a run of rows within each page
  assign lo_m     = (cur_pg == lo_pg) ? (BYTE_ONES << k_lo[2:0]) : BYTE_ONES;
  assign hi_m     = (cur_pg == hi_pg) ? (BYTE_ONES >> (BIT_TOP - k_hi[2:0])) : BYTE_ONES;
  assign run_mask = k_horiz ? (BYTE_ONE << k_c[2:0]) : (lo_m & hi_m);

  always_comb begin
    case (color_r)
      CLR_OFF: mod_data = rdata & ~p_mask;
      CLR_ON:  mod_data = rdata | p_mask;
      CLR_INV: mod_data = rdata ^ p_mask;
      default: mod_data = rdata;
    endcase
  end

  assign we     = cmd.sweep || (p_valid && is_draw);
  assign waddr  = cmd.sweep ? cur_addr : p_addr;
  assign wdata  = cmd.sweep ? 8'd0 : mod_data;
  assign box_ok = (bx_lo <= bx_hi) && (by_lo <= by_hi);

  mfb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur_addr),
    .rdata (rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r  <= func;
      x_r     <= pos_x;
      y_r     <= pos_y;
      len_r   <= length;
      color_r <= color;
      fpage_r <= fetch_page;
      fcol_r  <= fetch_column;
      pix_r   <= 1'b0;
      byte_r  <= 8'd0;
    end
    if (cmd.map) begin
      m_horiz <= horiz_n;
      m_a     <= a_n;
      m_c     <= c_n;
      m_len   <= lv;
    end
    if (cmd.clip) begin
      k_horiz <= m_horiz;
      k_ok    <= c_ok && (l2 > 0);
      k_lo    <= a0[7:0];
      k_hi    <= send[7:0];
      k_c     <= m_c[7:0];
    end
    if (cmd.issue) begin
      p_addr <= cur_addr;
      p_mask <= run_mask;
    end
    if (p_valid && func_r == FN_READ) begin
      pix_r <= rdata[row[2:0]];
    end
    if (p_valid && func_r == FN_FETCH) begin
      byte_r <= rdata;
    end
    if (cmd.load_out) begin
      pixel_value  <= pix_r;
      byte_data    <= byte_r;
      window_valid <= box_ok;
      dirty_x_low  <= bx_lo;
      dirty_y_low  <= by_lo;
      dirty_x_high <= bx_hi;
      dirty_y_high <= by_hi;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bx_lo    <= 8'd0;
      by_lo    <= 8'd0;
      bx_hi    <= RESET_WIDTH - 8'd1;
      by_hi    <= {1'b0, RESET_HEIGHT} - 8'd1;
      cur_addr <= '0;
      cnt      <= AW'(STORE_DEPTH - 1);
      cur_pg   <= '0;
      step     <= '0;
      p_valid  <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
      if (cmd.clip) begin
        if (func_r == FN_CLEAR) begin
          bx_lo <= 8'd0;
          by_lo <= 8'd0;
          bx_hi <= ew - 8'd1;
          by_hi <= {1'b0, eh} - 8'd1;
        end else if (func_r == FN_CLOSE && box_ok) begin
          bx_lo <= BYTE_ONES;
          by_lo <= BYTE_ONES;
          bx_hi <= 8'd0;
          by_hi <= 8'd0;
        end
      end
      if (cmd.setup) begin
        if (func_r == FN_CLEAR) begin
          cur_addr <= '0;
          cnt      <= AW'(STORE_DEPTH - 1);
        end else begin
          cur_addr <= prod[AW-1:0];
          cur_pg   <= lo_pg;
          if (func_r == FN_FETCH) begin
            cnt  <= '0;
            step <= '0;
          end else if (k_horiz) begin
            cnt  <= AW'(k_hi - k_lo);
            step <= AW'(1);
          end else begin
            cnt  <= AW'(hi_pg - lo_pg);
            step <= AW'(ew);
          end
        end
        if (is_draw && k_ok) begin
          if (k_horiz) begin
            if (k_lo < bx_lo) bx_lo <= k_lo;
            if (k_hi > bx_hi) bx_hi <= k_hi;
            if (k_c < by_lo)  by_lo <= k_c;
            if (k_c > by_hi)  by_hi <= k_c;
          end else begin
            if (k_c < bx_lo)  bx_lo <= k_c;
            if (k_c > bx_hi)  bx_hi <= k_c;
            if (k_lo < by_lo) by_lo <= k_lo;
            if (k_hi > by_hi) by_hi <= k_hi;
          end
        end
      end
      if (cmd.issue) begin
        cur_addr <= cur_addr + step;
        cur_pg   <= cur_pg + PG_W'(1);
        cnt      <= cnt - AW'(1);
      end
      if (cmd.sweep) begin
        cur_addr <= cur_addr + AW'(1);
        cnt      <= cnt - AW'(1);
      end
    end
  end

endmodule

/* design/mono_framebuffer_draw_engine.sv */
// Top level of the monochrome page-organized framebuffer draw engine.
// Usage:
//  - Commands enter on the in_valid/in_ready channel; each produces exactly
//    one result on the out_valid/out_ready channel (pixel value, fetched
//    byte and the dirty box after the command).
//  - Configuration (rotation, panel_width, panel_height) is written through
//    cfg_we/cfg_index/cfg_data while no command is in flight.
//  - One command at a time. Draws, reads and fetches touch N bytes of the
//    store, one read-modify-write per cycle through the single read and
//    write port of the store (N is up to 128 for a full-width line, up to
//    8 for a vertical line).
//  - Clear zeroes all 1024 bytes, one per cycle.
//  - After reset the store is zeroed by a sweep; in_ready stays
//    low until it ends. Configuration writes are taken during the sweep.
//  - The result register frees the engine: the next command is taken while
//    a result still waits; a stalled receiver only holds the engine once a
//    second result is ready.
module mono_framebuffer_draw_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        func,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  input  logic signed [9:0] length,
  input  logic [1:0]        color,
  input  logic [2:0]        fetch_page,
  input  logic [6:0]        fetch_column,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              pixel_value,
  output logic [7:0]        byte_data,
  output logic              window_valid,
  output logic [7:0]        dirty_x_low,
  output logic [7:0]        dirty_y_low,
  output logic [7:0]        dirty_x_high,
  output logic [7:0]        dirty_y_high
);
  import mfb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .length       (length),
    .color        (color),
    .fetch_page   (fetch_page),
    .fetch_column (fetch_column),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_value  (pixel_value),
    .byte_data    (byte_data),
    .window_valid (window_valid),
    .dirty_x_low  (dirty_x_low),
    .dirty_y_low  (dirty_y_low),
    .dirty_x_high (dirty_x_high),
    .dirty_y_high (dirty_y_high)
  );

endmodule
